/* rtl/ldp_pkg.sv */
// Shared types, constants and saturating add for the lens distortion pipeline.
package ldp_pkg;

    // Width of one partial-product chunk of the pipelined multipliers.
    localparam int CHUNK_W = 32;

    // Configuration register indexes.
    localparam logic [2:0] REG_K1 = 3'd0;
    localparam logic [2:0] REG_K2 = 3'd1;
    localparam logic [2:0] REG_K3 = 3'd2;
    localparam logic [2:0] REG_P1 = 3'd3;
    localparam logic [2:0] REG_P2 = 3'd4;

    typedef logic signed [63:0] wide_t;

    // Intermediates saturate to +/-(2^63 - 1).
    localparam wide_t W64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam wide_t W64_NEG = 64'sh8000_0000_0000_0001;

    typedef struct packed {
        logic signed [63:0] val;
        logic               ov;
    } sat_sum_t;

    function automatic sat_sum_t sat_add(input wide_t a, input wide_t b);
        logic signed [64:0] sum;
        sat_sum_t           r;
        sum = 65'(a) + 65'(b);
        if (sum > 65'(W64_MAX)) begin
            r.val = W64_MAX;
            r.ov  = 1'b1;
        end else if (sum < 65'(W64_NEG)) begin
            r.val = W64_NEG;
            r.ov  = 1'b1;
        end else begin
            r.val = sum[63:0];
            r.ov  = 1'b0;
        end
        return r;
    endfunction

endpackage

/* rtl/ldp_mulsh.sv */
// Four-stage signed multiply, truncating right shift and 64-bit saturation.
module ldp_mulsh #(
    parameter int AW = 32,
    parameter int BW = 32,
    parameter int SH = 24
) (
    input  logic                 clk,
    input  logic [3:0]           en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output ldp_pkg::wide_t       res,
    output logic                 ov
);

    localparam int CW = ldp_pkg::CHUNK_W;
    localparam int NA = AW / CW;
    localparam int NB = BW / CW;
    localparam int PW = AW + BW;

    logic [AW-1:0]   a_mag;
    logic [BW-1:0]   b_mag;
    logic [AW-1:0]   a_mag_reg;
    logic [BW-1:0]   b_mag_reg;
    logic [2:0]      neg_reg;
    logic [63:0]     pp_next [NA*NB];
    logic [63:0]     pp_reg  [NA*NB];
    logic [PW-1:0]   prod_next;
    logic [PW-1:0]   prod_reg;
    logic [PW-1:0]   quot;
    logic            sat;
    logic [63:0]     mag;
    ldp_pkg::wide_t  res_next;
    ldp_pkg::wide_t  res_reg;
    logic            ov_reg;

    // magnitudes; the most negative input maps to its unsigned value
    assign a_mag = a[AW-1] ? (~a + AW'(1)) : a;
    assign b_mag = b[BW-1] ? (~b + BW'(1)) : b;

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i*NB+j] = a_mag_reg[CW*i +: CW] * b_mag_reg[CW*j +: CW];
            end
        end
    end

    always_comb
    begin
        prod_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                prod_next = prod_next + (PW'(pp_reg[i*NB+j]) << (CW * (i + j)));
            end
        end
    end

    always_comb
    begin
        quot     = prod_reg >> SH;
        sat      = |quot[PW-1:63];
        mag      = sat ? 64'(ldp_pkg::W64_MAX) : quot[63:0];
        res_next = neg_reg[2] ? (~mag + 64'd1) : mag;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_mag_reg  <= a_mag;
            b_mag_reg  <= b_mag;
            neg_reg[0] <= a[AW-1] ^ b[BW-1];
        end
        if (en[1])
        begin
            for (int k = 0; k < NA*NB; k++)
            begin
                pp_reg[k] <= pp_next[k];
            end
            neg_reg[1] <= neg_reg[0];
        end
        if (en[2])
        begin
            prod_reg   <= prod_next;
            neg_reg[2] <= neg_reg[1];
        end
        if (en[3])
        begin
            res_reg <= res_next;
            ov_reg  <= sat;
        end
    end

    assign res = res_reg;
    assign ov  = ov_reg;

endmodule

/* rtl/lens_distortion_polynomial.sv */
// Radial (K1..K3) and tangential (P1/P2) lens distortion correction, pipelined.
// A result is valid once its item has passed through all 27 register stages (0 to 26).
// Throughput: one item per cycle unless stalled; a stage holds only while it and all stages
// after it are full and result_ready is low, so items still enter until the pipeline is full.
// Reset clears all stage valid bits and the five coefficients to zero; no other state.
module lens_distortion_polynomial #(
    parameter int COORD_FRAC = 24,
    parameter int COEF_FRAC  = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               point_valid,
    output logic               point_ready,
    input  logic signed [31:0] x_in,
    input  logic signed [31:0] y_in,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] x_out,
    output logic signed [31:0] y_out,
    output logic               overflow
);

    localparam int LAST = 26;

    localparam ldp_pkg::wide_t ONE_Q   = 64'sd1 <<< COORD_FRAC;
    localparam ldp_pkg::wide_t C32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam ldp_pkg::wide_t C32_MIN = 64'shFFFF_FFFF_8000_0000;

    // coefficients
    logic signed [31:0] k1_reg, k2_reg, k3_reg, p1_reg, p2_reg;

    // stage control
    logic [LAST:0] vld_reg;
    logic [LAST:0] en;
    logic [LAST:1] flag;
    logic          ov_reg [0:LAST];

    // stage payload
    logic signed [31:0] x_reg [0:19];
    logic signed [31:0] y_reg [0:19];
    ldp_pkg::wide_t     r2_reg [5:9];
    ldp_pkg::wide_t     xx2_reg, yy2_reg, ax_reg, ay_reg;
    ldp_pkg::wide_t     uux_reg [9:24];
    ldp_pkg::wide_t     uuy_reg [9:24];
    ldp_pkg::wide_t     tx_reg [11:23];
    ldp_pkg::wide_t     ty_reg [11:23];
    ldp_pkg::wide_t     k1r2_reg [10:13];
    ldp_pkg::wide_t     s1_reg [14:17];
    ldp_pkg::wide_t     s2_reg, s_reg, vx_reg, vy_reg, xo_reg, yo_reg;
    logic signed [31:0] x_out_reg, y_out_reg;

    // multiplier results
    ldp_pkg::wide_t x2_res, y2_res, xy_res, r4_res, k1r2_res, ux_res, uy_res;
    ldp_pkg::wide_t tx_res, ty_res, r6_res, k2r4_res, k3r6_res, xs_res, ys_res;
    logic ov_x2, ov_y2, ov_xy, ov_r4, ov_k1r2, ov_ux, ov_uy;
    logic ov_tx, ov_ty, ov_r6, ov_k2r4, ov_k3r6, ov_xs, ov_ys;

    // saturating sums
    ldp_pkg::sat_sum_t r2_next, xx2_next, yy2_next, ax_next, ay_next;
    ldp_pkg::sat_sum_t uux_next, uuy_next, s1_next, s2_next, s_next;
    ldp_pkg::sat_sum_t vx_next, vy_next, xo_next, yo_next;

    logic signed [31:0] x_clamp, y_clamp;
    logic               x_clip, y_clip;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg <= '0;
            k2_reg <= '0;
            k3_reg <= '0;
            p1_reg <= '0;
            p2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ldp_pkg::REG_K1: k1_reg <= cfg_data;
                ldp_pkg::REG_K2: k2_reg <= cfg_data;
                ldp_pkg::REG_K3: k3_reg <= cfg_data;
                ldp_pkg::REG_P1: p1_reg <= cfg_data;
                ldp_pkg::REG_P2: p2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage moves when it is empty or everything after it can move
    for (genvar n = 0; n <= LAST; n++)
    begin : g_en
        assign en[n] = result_ready || !(&vld_reg[LAST:n]);
    end

    assign point_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= point_valid;
            end
            for (int n = 1; n <= LAST; n++)
            begin
                if (en[n])
                begin
                    vld_reg[n] <= vld_reg[n-1];
                end
            end
        end
    end

    // multipliers: inputs at stage n, result registered at stage n+4
    ldp_mulsh #(.AW(32), .BW(32), .SH(COORD_FRAC)) u_x2 (
        .clk(clk), .en(en[4:1]), .a(x_reg[0]), .b(x_reg[0]), .res(x2_res), .ov(ov_x2));
    ldp_mulsh #(.AW(32), .BW(32), .SH(COORD_FRAC)) u_y2 (
        .clk(clk), .en(en[4:1]), .a(y_reg[0]), .b(y_reg[0]), .res(y2_res), .ov(ov_y2));
    ldp_mulsh #(.AW(32), .BW(32), .SH(COORD_FRAC)) u_xy (
        .clk(clk), .en(en[4:1]), .a(x_reg[0]), .b(y_reg[0]), .res(xy_res), .ov(ov_xy));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_ux (
        .clk(clk), .en(en[8:5]), .a(p2_reg), .b(xy_res), .res(ux_res), .ov(ov_ux));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_uy (
        .clk(clk), .en(en[8:5]), .a(p1_reg), .b(xy_res), .res(uy_res), .ov(ov_uy));
    ldp_mulsh #(.AW(64), .BW(64), .SH(COORD_FRAC)) u_r4 (
        .clk(clk), .en(en[9:6]), .a(r2_reg[5]), .b(r2_reg[5]), .res(r4_res), .ov(ov_r4));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_k1r2 (
        .clk(clk), .en(en[9:6]), .a(k1_reg), .b(r2_reg[5]), .res(k1r2_res), .ov(ov_k1r2));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_tx (
        .clk(clk), .en(en[10:7]), .a(p1_reg), .b(ax_reg), .res(tx_res), .ov(ov_tx));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_ty (
        .clk(clk), .en(en[10:7]), .a(p2_reg), .b(ay_reg), .res(ty_res), .ov(ov_ty));
    ldp_mulsh #(.AW(64), .BW(64), .SH(COORD_FRAC)) u_r6 (
        .clk(clk), .en(en[13:10]), .a(r4_res), .b(r2_reg[9]), .res(r6_res), .ov(ov_r6));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_k2r4 (
        .clk(clk), .en(en[13:10]), .a(k2_reg), .b(r4_res), .res(k2r4_res), .ov(ov_k2r4));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COEF_FRAC)) u_k3r6 (
        .clk(clk), .en(en[17:14]), .a(k3_reg), .b(r6_res), .res(k3r6_res), .ov(ov_k3r6));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COORD_FRAC)) u_xs (
        .clk(clk), .en(en[23:20]), .a(x_reg[19]), .b(s_reg), .res(xs_res), .ov(ov_xs));
    ldp_mulsh #(.AW(32), .BW(64), .SH(COORD_FRAC)) u_ys (
        .clk(clk), .en(en[23:20]), .a(y_reg[19]), .b(s_reg), .res(ys_res), .ov(ov_ys));

    always_comb
    begin
        r2_next  = ldp_pkg::sat_add(x2_res, y2_res);
        xx2_next = ldp_pkg::sat_add(x2_res, x2_res);
        yy2_next = ldp_pkg::sat_add(y2_res, y2_res);
        ax_next  = ldp_pkg::sat_add(r2_reg[5], xx2_reg);
        ay_next  = ldp_pkg::sat_add(r2_reg[5], yy2_reg);
        uux_next = ldp_pkg::sat_add(ux_res, ux_res);
        uuy_next = ldp_pkg::sat_add(uy_res, uy_res);
        s1_next  = ldp_pkg::sat_add(k1r2_reg[13], k2r4_res);
        s2_next  = ldp_pkg::sat_add(s1_reg[17], k3r6_res);
        s_next   = ldp_pkg::sat_add(s2_reg, ONE_Q);
        vx_next  = ldp_pkg::sat_add(xs_res, tx_reg[23]);
        vy_next  = ldp_pkg::sat_add(ys_res, ty_reg[23]);
        xo_next  = ldp_pkg::sat_add(vx_reg, uux_reg[24]);
        yo_next  = ldp_pkg::sat_add(vy_reg, uuy_reg[24]);
    end

    // clamp to the 32-bit output range
    always_comb
    begin
        x_clip = 1'b0;
        y_clip = 1'b0;
        if (xo_reg > C32_MAX)
        begin
            x_clamp = 32'sh7FFF_FFFF;
            x_clip  = 1'b1;
        end
        else if (xo_reg < C32_MIN)
        begin
            x_clamp = 32'sh8000_0000;
            x_clip  = 1'b1;
        end
        else
        begin
            x_clamp = xo_reg[31:0];
        end
        if (yo_reg > C32_MAX)
        begin
            y_clamp = 32'sh7FFF_FFFF;
            y_clip  = 1'b1;
        end
        else if (yo_reg < C32_MIN)
        begin
            y_clamp = 32'sh8000_0000;
            y_clip  = 1'b1;
        end
        else
        begin
            y_clamp = yo_reg[31:0];
        end
    end

    // saturation flags joining the item's overflow bit at each stage;
    // a multiplier flag sitting in stage m is merged into stage m+1
    always_comb
    begin
        flag     = '0;
        flag[5]  = ov_x2 | ov_y2 | ov_xy | r2_next.ov | xx2_next.ov | yy2_next.ov;
        flag[6]  = ax_next.ov | ay_next.ov;
        flag[9]  = ov_ux | ov_uy | uux_next.ov | uuy_next.ov;
        flag[10] = ov_r4 | ov_k1r2;
        flag[11] = ov_tx | ov_ty;
        flag[14] = ov_r6 | ov_k2r4 | s1_next.ov;
        flag[18] = ov_k3r6 | s2_next.ov;
        flag[19] = s_next.ov;
        flag[24] = ov_xs | ov_ys | vx_next.ov | vy_next.ov;
        flag[25] = xo_next.ov | yo_next.ov;
        flag[26] = x_clip | y_clip;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]  <= x_in;
            y_reg[0]  <= y_in;
            ov_reg[0] <= 1'b0;
        end
        for (int n = 1; n <= 19; n++)
        begin
            if (en[n])
            begin
                x_reg[n] <= x_reg[n-1];
                y_reg[n] <= y_reg[n-1];
            end
        end
        for (int n = 1; n <= LAST; n++)
        begin
            if (en[n])
            begin
                ov_reg[n] <= ov_reg[n-1] | flag[n];
            end
        end

        if (en[5])
        begin
            r2_reg[5] <= r2_next.val;
            xx2_reg   <= xx2_next.val;
            yy2_reg   <= yy2_next.val;
        end
        for (int n = 6; n <= 9; n++)
        begin
            if (en[n])
            begin
                r2_reg[n] <= r2_reg[n-1];
            end
        end
        if (en[6])
        begin
            ax_reg <= ax_next.val;
            ay_reg <= ay_next.val;
        end

        if (en[9])
        begin
            uux_reg[9] <= uux_next.val;
            uuy_reg[9] <= uuy_next.val;
        end
        for (int n = 10; n <= 24; n++)
        begin
            if (en[n])
            begin
                uux_reg[n] <= uux_reg[n-1];
                uuy_reg[n] <= uuy_reg[n-1];
            end
        end

        if (en[11])
        begin
            tx_reg[11] <= tx_res;
            ty_reg[11] <= ty_res;
        end
        for (int n = 12; n <= 23; n++)
        begin
            if (en[n])
            begin
                tx_reg[n] <= tx_reg[n-1];
                ty_reg[n] <= ty_reg[n-1];
            end
        end

        if (en[10])
        begin
            k1r2_reg[10] <= k1r2_res;
        end
        for (int n = 11; n <= 13; n++)
        begin
            if (en[n])
            begin
                k1r2_reg[n] <= k1r2_reg[n-1];
            end
        end

        if (en[14])
        begin
            s1_reg[14] <= s1_next.val;
        end
        for (int n = 15; n <= 17; n++)
        begin
            if (en[n])
            begin
                s1_reg[n] <= s1_reg[n-1];
            end
        end

        if (en[18])
        begin
            s2_reg <= s2_next.val;
        end
        if (en[19])
        begin
            s_reg <= s_next.val;
        end
        if (en[24])
        begin
            vx_reg <= vx_next.val;
            vy_reg <= vy_next.val;
        end
        if (en[25])
        begin
            xo_reg <= xo_next.val;
            yo_reg <= yo_next.val;
        end
        if (en[26])
        begin
            x_out_reg <= x_clamp;
            y_out_reg <= y_clamp;
        end
    end

    assign result_valid = vld_reg[LAST];
    assign x_out        = x_out_reg;
    assign y_out        = y_out_reg;
    assign overflow     = ov_reg[LAST];

endmodule
